FILE: rtl/threshold_split_amount_sorter_macros.svh
// ----------------------------------------------------------------------------
// Threshold split amount sorter assertion macros
// Shared property wrappers, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_SPLIT_AMOUNT_SORTER_MACROS_SVH
`define THRESHOLD_SPLIT_AMOUNT_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tsas_pkg.sv
// ----------------------------------------------------------------------------
// tsas_pkg
// Widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tsas_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int AMOUNT_W    = 62;
   localparam int TAG_W       = 32;
   localparam int FEE_W       = 32;
   localparam int THR_W       = 64;
   localparam int DATA_W      = 96;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 62;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_OUTPUT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FEE_PER_KB   = 1'b1;

   typedef struct packed {
      logic [AMOUNT_W-1:0] amount;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   typedef struct packed {
      logic load_item;
      logic drop;
      logic ins_read;
      logic ins_shift;
      logic ins_place;
      logic scan_start;
      logic scan_step;
      logic out_init;
      logic out_read;
      logic out_load;
      logic out_next;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic pos_zero;
      logic pos_one;
      logic greater;
      logic above;
      logic scan_end;
      logic out_last;
   } status_type;

endpackage

FILE: rtl/tsas_ctrl.sv
// ----------------------------------------------------------------------------
// tsas_ctrl
// Sequencer for loading, insertion, threshold scan and ordered read-out.
// ----------------------------------------------------------------------------
module tsas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tsas_pkg::status_type status,
   output tsas_pkg::cmd_type    cmd
);
   import tsas_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_RD   = 4'd1;
   localparam logic [3:0] S_INS_CMP  = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CMP = 4'd4;
   localparam logic [3:0] S_OUT_RD   = 4'd5;
   localparam logic [3:0] S_OUT_LD   = 4'd6;
   localparam logic [3:0] S_OUT_HOLD = 4'd7;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [3:0] after_item;

   // Once an item is stored or dropped, a closing item starts the scan.
   assign after_item = status.last ? S_SCAN_RD : S_IDLE;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT_HOLD);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (status.full) begin
               cmd.drop = 1'b1;
               state_in = after_item;
            end else if (status.pos_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = after_item;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.greater) begin
               cmd.ins_shift = 1'b1;
               state_in      = status.pos_one ? S_INS_RD : S_INS_CMP;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = after_item;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (status.above || status.scan_end) begin
               cmd.out_init = 1'b1;
               state_in     = S_OUT_RD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_OUT_RD: begin
            cmd.out_read = 1'b1;
            state_in     = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_tready) begin
               if (status.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tsas_dp.sv
// ----------------------------------------------------------------------------
// tsas_dp
// Entry memory, item and configuration registers, counters and comparators.
// ----------------------------------------------------------------------------
module tsas_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tsas_pkg::DATA_W-1:0]          req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 csr_we,
   input  logic [tsas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsas_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tsas_pkg::cmd_type                    cmd,
   output tsas_pkg::status_type                 status,
   output logic [tsas_pkg::DATA_W-1:0]          rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);
   import tsas_pkg::*;

   entry_type             mem [MAX_ENTRIES];
   entry_type             rd_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_data;

   logic [AMOUNT_W-1:0]   total_ff;
   logic [FEE_W-1:0]      fee_ff;
   logic [THR_W-1:0]      thr_ff;
   entry_type             item_ff;
   logic                  last_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  ovf_ff;
   logic [ADDR_W-1:0]     pos_ff;
   logic [ADDR_W-1:0]     idx_ff;
   logic [ADDR_W-1:0]     k_ff;
   logic                  down_ff;
   logic [CNT_W-1:0]      left_ff;
   entry_type             rsp_data_ff;
   logic                  rsp_last_ff;
   logic                  rsp_ovf_ff;
   logic [ADDR_W-1:0]     k_sel;

   assign status.full     = (count_ff == CNT_W'(MAX_ENTRIES));
   assign status.last     = last_ff;
   assign status.pos_zero = (pos_ff == '0);
   assign status.pos_one  = (pos_ff == ADDR_W'(1));
   assign status.greater  = (rd_ff.amount > item_ff.amount);
   assign status.above    = ({2'b00, rd_ff.amount} > thr_ff);
   assign status.scan_end = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign status.out_last = (left_ff == CNT_W'(1));

   assign k_sel = status.above ? idx_ff : '0;

   always_comb begin
      rd_addr = pos_ff;
      if (cmd.ins_read) begin
         rd_addr = pos_ff - ADDR_W'(1);
      end else if (cmd.ins_shift) begin
         rd_addr = pos_ff - ADDR_W'(2);
      end else if (cmd.scan_start) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = idx_ff + ADDR_W'(1);
      end else if (cmd.out_read) begin
         rd_addr = pos_ff;
      end
   end

   assign wr_en   = cmd.ins_shift | cmd.ins_place;
   assign wr_addr = pos_ff;
   assign wr_data = cmd.ins_shift ? rd_ff : item_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         fee_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_TOTAL_OUTPUT) begin
            total_ff <= csr_wdata[AMOUNT_W-1:0];
         end
         if (csr_index == REG_FEE_PER_KB) begin
            fee_ff <= csr_wdata[FEE_W-1:0];
         end
      end
   end

   // Set bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.finish) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.ins_place) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.drop) begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // Item, threshold, position and output registers carry payload only.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff.amount <= req_tdata[AMOUNT_W-1:0];
         item_ff.tag    <= req_tdata[AMOUNT_W+TAG_W-1:AMOUNT_W];
         last_ff        <= req_tlast;
         thr_ff         <= {1'b0, total_ff, 1'b0} + {{(THR_W-FEE_W){1'b0}}, fee_ff};
         pos_ff         <= count_ff[ADDR_W-1:0];
      end
      if (cmd.ins_shift) begin
         pos_ff <= pos_ff - ADDR_W'(1);
      end
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.out_init) begin
         k_ff    <= k_sel;
         down_ff <= (k_sel != '0);
         pos_ff  <= (k_sel == '0) ? '0 : k_sel - ADDR_W'(1);
         left_ff <= count_ff;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= rd_ff;
         rsp_last_ff <= status.out_last;
         rsp_ovf_ff  <= ovf_ff;
      end
      if (cmd.out_next) begin
         left_ff <= left_ff - CNT_W'(1);
         if (down_ff) begin
            if (pos_ff == '0) begin
               pos_ff  <= k_ff;
               down_ff <= 1'b0;
            end else begin
               pos_ff <= pos_ff - ADDR_W'(1);
            end
         end else begin
            pos_ff <= pos_ff + ADDR_W'(1);
         end
      end
   end

   assign rsp_tdata = {{(DATA_W-AMOUNT_W-TAG_W){1'b0}}, rsp_data_ff.tag, rsp_data_ff.amount};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_ovf_ff;

endmodule

FILE: rtl/threshold_split_amount_sorter.sv
// Loading: each entry is walked down past every stored entry of larger amount before it is placed;
// the first entry of a set is placed, and an entry dropped for lack of room discarded, without a read.
// Read-out: the threshold scan examines entries in turn until one is above the threshold, and each
// result is then read, loaded and held until the result side takes it; all steps share one memory read port.
// One item is in work at a time; the input is not ready while a set is being read out.
// Reset is synchronous and active high; it empties the set and zeroes both registers.
// ----------------------------------------------------------------------------
// threshold_split_amount_sorter
// Sorts a loaded set of coin entries by amount and emits them around a threshold.
// ----------------------------------------------------------------------------
`include "threshold_split_amount_sorter_macros.svh"

module threshold_split_amount_sorter (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tsas_pkg::DATA_W-1:0]          req_tdata,  // amount[61:0], tag[93:62], zero pad
   input  logic                                 req_tlast,  // last_entry
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tsas_pkg::DATA_W-1:0]          rsp_tdata,  // out_amount[61:0], out_tag[93:62], pad
   output logic                                 rsp_tlast,  // last_result
   output logic                                 rsp_tuser,  // overflow
   // Configuration writes: index 0 is total_output_amount, index 1 is fee_per_kb.
   input  logic                                 csr_we,
   input  logic [tsas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsas_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tsas_pkg::*;

   // The controller only issues commands and the datapath only reports status flags.
   cmd_type    ctrl_cmd;
   status_type dp_status;

   // The sequencer walks each new entry down the sorted memory one slot per cycle, scans for
   // the first amount above twice the output total plus the fee rate, and then reads out the
   // entries below that point in descending order and the rest ascending; with none above, all ascending.
   tsas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (ctrl_cmd)
   );

   // The datapath holds the entry memory, the counters and the result register.
   tsas_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   // A result is never offered while the input side is open.
   `TSAS_ASSERT_SAME(a_no_overlap, rsp_tvalid, !req_tready, "result offered while input open")
   // The final result of a run hands control back to loading.
   `TSAS_ASSERT_NEXT(a_run_ends, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "no reload")
   // Only one memory write command may be issued in a cycle.
   `TSAS_ASSERT_SAME(a_one_write, ctrl_cmd.ins_shift, !ctrl_cmd.ins_place, "two writes")
   // A shift only happens while the stored entry is larger than the new one.
   `TSAS_ASSERT_SAME(a_shift_cause, ctrl_cmd.ins_shift, dp_status.greater, "bad shift")

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Threshold split amount sorter testbench
// Loads sets of coin entries through the item stream and predicts, for each
// closing item, the sorted entries in their split order around the threshold.
// Every result item is checked field by field against that prediction.
// Both stream sides idle at random, and the result side is held off for a
// long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsas_pkg::*;

   // The limit is set well above the slowest correct run.
   localparam int CYCLE_LIMIT   = 400000;
   // This covers any work still in hand when the last expected result arrives.
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_IDLE      = 12;
   localparam int RANDOM_ITEMS  = 12;

   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;
   localparam logic [TAG_W-1:0]    TAG_MAX    = '1;

   // One expected result item.
   typedef struct packed {
      logic [AMOUNT_W-1:0] amount;
      logic [TAG_W-1:0]    tag;
      logic                last;
      logic                overflow;
   } result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;  // amount[61:0], tag[93:62], zero pad
   logic                  req_tlast  = 1'b0; // last_entry
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;         // out_amount[61:0], out_tag[93:62], pad
   logic                  rsp_tlast;         // last_result
   logic                  rsp_tuser;         // overflow
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Our own copy of the block's registers and of the set being loaded. The
   // set is kept in sorted order, equal amounts in the order they arrived.
   logic [AMOUNT_W-1:0]   total_output;
   logic [FEE_W-1:0]      fee_rate;
   entry_type             sorted_coins[$];
   logic                  coins_dropped;
   result_type            expected_results[$];

   int                    cycle_count  = 0;
   int                    error_count  = 0;
   // Idling switches for the two sides, and the receiver's stall counter.
   bit                    req_idle     = 1'b1;
   bit                    rsp_idle     = 1'b1;
   bit                    hold_wanted  = 1'b0;
   int                    rsp_stall    = 0;

   threshold_split_amount_sorter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a run that stops making progress ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // The threshold is twice the output total plus the fee rate. It is formed
   // in 64 bits, where the largest settings still fit.
   function automatic logic [THR_W-1:0] split_threshold();
      return (THR_W'(total_output) << 1) + THR_W'(fee_rate);
   endfunction

   // Takes one accepted entry. Entries past capacity are dropped and remembered;
   // the closing entry releases the whole set as expected result items: the
   // entries at or below the threshold from the largest down, then the rest in
   // ascending order; with none above it, the whole set in ascending order.
   function automatic void sort_and_split(input logic [AMOUNT_W-1:0] amount,
                                          input logic [TAG_W-1:0] tag,
                                          input logic last);
      entry_type        coin;
      result_type       result;
      logic [THR_W-1:0] threshold;
      int               pos;
      int               split;
      int               count;
      int               j;
      if (sorted_coins.size() < MAX_ENTRIES) begin
         pos = sorted_coins.size();
         while (pos > 0 && sorted_coins[pos-1].amount > amount)
            pos--;
         coin.amount = amount;
         coin.tag    = tag;
         sorted_coins.insert(pos, coin);
      end else begin
         coins_dropped = 1'b1;
      end
      if (!last)
         return;
      threshold = split_threshold();
      count     = sorted_coins.size();
      // The split point is the first entry strictly above the threshold; with
      // none above it the split stays at zero and the order is plain ascending.
      split = 0;
      for (j = 0; j < count; j++) begin
         if (THR_W'(sorted_coins[j].amount) > threshold) begin
            split = j;
            break;
         end
      end
      for (j = 0; j < count; j++) begin
         pos             = (j < split) ? split - 1 - j : j;
         result.amount   = sorted_coins[pos].amount;
         result.tag      = sorted_coins[pos].tag;
         result.last     = (j == count - 1);
         result.overflow = coins_dropped;
         expected_results.insert(expected_results.size(), result);
      end
      sorted_coins.delete();
      coins_dropped = 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Every accepted result item is held against the oldest expectation.
   // Afterwards the receiver draws how long it waits before the next one.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result item, amount %h tag %h",
                                      rsp_tdata[AMOUNT_W-1:0],
                                      rsp_tdata[AMOUNT_W+TAG_W-1:AMOUNT_W]));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[AMOUNT_W-1:0] !== want.amount)
               report_mismatch($sformatf("out_amount %h, expected %h",
                                         rsp_tdata[AMOUNT_W-1:0], want.amount));
            if (rsp_tdata[AMOUNT_W+TAG_W-1:AMOUNT_W] !== want.tag)
               report_mismatch($sformatf("out_tag %h, expected %h",
                                         rsp_tdata[AMOUNT_W+TAG_W-1:AMOUNT_W], want.tag));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_result %b, expected %b",
                                         rsp_tlast, want.last));
            if (rsp_tuser !== want.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_tuser, want.overflow));
         end
         rsp_stall = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
   end

   // The receiver counts down its stall at each falling edge. A requested
   // hold-off replaces the stall with one long stretch.
   initial begin : result_receiver
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall   = HOLD_CYCLES;
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one entry and returns at the edge where it is accepted. The valid
   // is left high, so that a following entry may go out without a gap.
   task automatic send_entry(input logic [AMOUNT_W-1:0] amount,
                             input logic [TAG_W-1:0] tag, input logic last);
      int gap;
      gap = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({tag, amount});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sort_and_split(amount, tag, last);
   endtask

   // Withdraws the offer and waits until the block has delivered everything
   // and settled, so that the registers may safely be written.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == REG_TOTAL_OUTPUT)
         total_output = value;
      else
         fee_rate = value[FEE_W-1:0];
   endtask

   // Amounts are drawn from the whole range, from a narrow low range that
   // makes ties likely, from close around the threshold, and from the ends.
   function automatic logic [AMOUNT_W-1:0] draw_amount();
      logic [THR_W-1:0] near;
      case ($urandom_range(0, 3))
         0: return AMOUNT_W'({$urandom, $urandom});
         1: return AMOUNT_W'($urandom_range(0, 15));
         2: begin
            near = split_threshold();
            near = (near < 4) ? THR_W'($urandom_range(0, 8))
                              : near - 4 + THR_W'($urandom_range(0, 8));
            if (near > THR_W'(AMOUNT_MAX))
               near = THR_W'(AMOUNT_MAX) - THR_W'($urandom_range(0, 3));
            return near[AMOUNT_W-1:0];
         end
         default: return $urandom_range(0, 1) ? AMOUNT_MAX : '0;
      endcase
   endfunction

   task automatic send_random_set(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_entry(draw_amount(), $urandom, i == count - 1);
   endtask

   // Registers are only ever changed here once the block has gone quiet.
   task automatic randomise_registers();
      case ($urandom_range(0, 3))
         0: begin
            write_register(REG_TOTAL_OUTPUT, CSR_DATA_W'($urandom_range(0, 500)));
            write_register(REG_FEE_PER_KB, CSR_DATA_W'($urandom_range(0, 500)));
         end
         1: begin
            // Bits above the fee field are written too; the block keeps only
            // the low 32.
            write_register(REG_TOTAL_OUTPUT, CSR_DATA_W'({$urandom, $urandom}));
            write_register(REG_FEE_PER_KB, CSR_DATA_W'({$urandom, $urandom}));
         end
         2: begin
            write_register(REG_TOTAL_OUTPUT, CSR_DATA_W'({$urandom, $urandom}) >> 3);
            write_register(REG_FEE_PER_KB, CSR_DATA_W'($urandom));
         end
         default: begin
            write_register(REG_TOTAL_OUTPUT, $urandom_range(0, 1) ? AMOUNT_MAX : '0);
            write_register(REG_FEE_PER_KB, $urandom_range(0, 1) ? CSR_DATA_W'(TAG_MAX) : '0);
         end
      endcase
   endtask

   // With both registers at their reset value the threshold is zero: an entry
   // of amount zero is not above it, an entry of the largest amount is.
   task automatic test_single_entry_sets();
      send_entry('0, '0, 1'b1);
      send_entry(AMOUNT_MAX, TAG_MAX, 1'b1);
      wait_for_results();
   endtask

   // Threshold of 250. The two entries of exactly 250 stay below the split and
   // so come out first, in reverse of their load order, then 10, 5, 251, 300.
   task automatic test_threshold_split();
      write_register(REG_TOTAL_OUTPUT, 62'd100);
      write_register(REG_FEE_PER_KB, 62'd50);
      send_entry(62'd250, 32'h0000_00a1, 1'b0);
      send_entry(62'd251, 32'h0000_00b2, 1'b0);
      send_entry(62'd10, 32'h0000_00c3, 1'b0);
      send_entry(62'd300, 32'h0000_00d4, 1'b0);
      send_entry(62'd250, 32'h0000_00e5, 1'b0);
      send_entry(62'd5, 32'h0000_00f6, 1'b1);
      wait_for_results();
   endtask

   // Every entry is above a zero threshold, so the split falls at the first
   // position and the set comes out in plain ascending order.
   task automatic test_all_above_threshold();
      write_register(REG_TOTAL_OUTPUT, '0);
      write_register(REG_FEE_PER_KB, '0);
      send_entry(62'd3, 32'h3333_3333, 1'b0);
      send_entry(62'd1, 32'h1111_1111, 1'b0);
      send_entry(62'd2, 32'h2222_2222, 1'b1);
      wait_for_results();
   endtask

   task automatic test_register_extremes();
      // Both registers at their largest: the threshold exceeds any amount,
      // and the doubling must not wrap.
      write_register(REG_TOTAL_OUTPUT, AMOUNT_MAX);
      write_register(REG_FEE_PER_KB, '1);
      send_entry(AMOUNT_MAX, '0, 1'b0);
      send_entry('0, TAG_MAX, 1'b0);
      send_entry(AMOUNT_MAX, 32'h0000_1234, 1'b0);
      send_entry('0, '0, 1'b1);
      wait_for_results();
      // The fee alone sets the threshold, right at the carry into bit 32.
      write_register(REG_TOTAL_OUTPUT, '0);
      write_register(REG_FEE_PER_KB, CSR_DATA_W'(TAG_MAX));
      send_entry(62'h1_0000_0000, 32'h5555_aaaa, 1'b0);
      send_entry(62'h0_ffff_ffff, 32'haaaa_5555, 1'b0);
      send_entry(AMOUNT_MAX, 32'h0f0f_0f0f, 1'b0);
      send_entry(62'd7, 32'hf0f0_f0f0, 1'b1);
      wait_for_results();
   endtask

   // A set that fills the store exactly raises no overflow. The next one runs
   // past capacity, and its closing item is itself dropped yet still ends it.
   task automatic test_full_set();
      int i;
      write_register(REG_TOTAL_OUTPUT, 62'd10);
      write_register(REG_FEE_PER_KB, 62'd3);
      send_random_set(MAX_ENTRIES);
      wait_for_results();
      for (i = 0; i < MAX_ENTRIES; i++)
         send_entry(draw_amount(), $urandom, 1'b0);
      send_entry(draw_amount(), $urandom, 1'b1);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering without gaps; the block must stall its input rather than lose
   // anything. The sender then waits until every result has come.
   task automatic test_output_stall();
      req_idle    = 1'b0;
      hold_wanted = 1'b1;
      send_random_set(5);
      send_random_set(5);
      send_random_set(5);
      wait_for_results();
      req_idle = 1'b1;
   endtask

   task automatic test_random_sets();
      int sent;
      int count;
      sent = 0;
      randomise_registers();
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_for_results();
            randomise_registers();
         end
         // Now and then one side, or both, run without any idling.
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         count = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                             : $urandom_range(1, 10);
         send_random_set(count);
         sent += count;
      end
      wait_for_results();
   endtask

   initial begin
      total_output  = '0;
      fee_rate      = '0;
      coins_dropped = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_single_entry_sets();
      test_threshold_split();
      test_all_above_threshold();
      test_register_extremes();
      test_full_set();
      test_output_stall();
      test_random_sets();

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
